// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- rtl/uts_pkg.sv -----
// Types and constants of the UTF-8 text sanitizer filter.
package uts_pkg;

  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChHash    = 8'h23;
  localparam logic [7:0] ChDash    = 8'h2D;
  localparam logic [7:0] Lead4Min  = 8'hF0;
  localparam logic [7:0] Lead3Min  = 8'hE0;
  localparam logic [7:0] LeadMask  = 8'h0F;
  localparam logic [7:0] ContMask  = 8'h3F;
  localparam logic [15:0] CpBullet = 16'h2022;
  localparam logic [15:0] CpSymLo  = 16'h2600;
  localparam logic [15:0] CpSymHi  = 16'h27BF;
  localparam logic [15:0] CpVsLo   = 16'hFE00;
  localparam logic [15:0] CpVsHi   = 16'hFE0F;

  // Input beat.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       end_mark;
  } out_beat_t;

  // All results caused by one input beat; num is 1..3.
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      num;
    logic            present;
    logic            last;
  } bundle_t;

  function automatic logic is_markup(input logic [7:0] b);
    return (b == ChStar) || (b == ChHash);
  endfunction

endpackage

// ----- rtl/utf8_text_sanitizer_filter.sv -----
// Top level of the UTF-8 text sanitizer filter.
//
// Byte-serial cleaner for UTF-8 text. '*' and '#' are dropped; a lead byte of
// 0xF0 or above is swallowed with its next three bytes; a 0xE0..0xEF lead is
// decoded with its next two bytes, U+2022 turns into '-', U+2600..U+27BF and
// U+FE00..U+FE0F vanish, other code points pass unchanged. A sequence cut off
// by end_of_text goes out as plain bytes (markup among the trailing bytes
// still dropped), and a final byte that yields nothing produces a bare result
// with byte_present low and end_mark high. Both sides are queue style: a beat
// enters when push is high and full low, and a result leaves when pop is high
// and empty low. Throughput: one input beat per cycle while the bundle queue
// has room; each result takes one pop cycle, and an input beat produces at
// most three. The front stage builds all results of a beat in the cycle it is
// accepted and writes them as one bundle into a FIFO_DEPTH-entry queue whose
// head drives the output. Output never outnumbers input, so at the default
// FIFO_DEPTH a steady sink taking one result per cycle never stalls the
// source; FIFO_DEPTH sets how long a burst of multi-result beats the block
// can absorb while the sink waits. No clearing pass after reset.
module utf8_text_sanitizer_filter import uts_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  output logic      full,
  input  in_beat_t  in_beat_i,
  output logic      empty,
  input  logic      pop,
  output out_beat_t out_beat_o
);

  logic    wr_en;
  bundle_t wr_bundle;
  bundle_t head;
  logic    q_full, q_empty, q_pop;

  assign full = q_full;

  // front: classification and sequence hold state
  uts_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .q_full_i  (q_full),
    .in_beat_i (in_beat_i),
    .wr_en_o   (wr_en),
    .bundle_o  (wr_bundle)
  );

  // decoupling queue, one entry per input beat that has results
  uts_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_bundle),
    .rd_en_i   (q_pop),
    .rd_data_o (head),
    .full_o    (q_full),
    .empty_o   (q_empty)
  );

  // back: serializes bundles into result beats
  uts_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_beat_o (out_beat_o)
  );

endmodule

// ----- rtl/uts_front.sv -----
// Front stage: accepts input beats, tracks multibyte sequences, builds result bundles.
module uts_front import uts_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  logic     q_full_i,
  input  in_beat_t in_beat_i,
  output logic     wr_en_o,
  output bundle_t  bundle_o
);

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_FOUR  = 2'd1,
    MODE_THREE = 2'd2
  } mode_e;

  mode_e      mode_q, mode_d;
  logic [7:0] lead_q, lead_d;
  logic [7:0] fol_q, fol_d;
  logic [1:0] cnt_q, cnt_d;

  logic       accept;
  bundle_t    bnd;
  logic [7:0] b;
  logic       last;
  logic [15:0] cp;
  logic       keep_f, keep_b;

  assign accept = push_i & ~q_full_i;
  assign b      = in_beat_i.data_byte;
  assign last   = in_beat_i.end_of_text;
  // lead keeps its low nibble, followers their low six bits
  assign cp     = {lead_q[3:0], fol_q[5:0], b[5:0]};
  assign keep_f = (cnt_q == 2'd1) && !is_markup(fol_q);
  assign keep_b = !is_markup(b);

  always_comb begin
    mode_d      = mode_q;
    lead_d      = lead_q;
    fol_d       = fol_q;
    cnt_d       = cnt_q;
    bnd.data    = '0;
    bnd.num     = 2'd0;
    bnd.present = 1'b1;
    bnd.last    = last;

    unique case (mode_q)
      MODE_FOUR, MODE_THREE: begin
        if ((mode_q == MODE_FOUR && cnt_q == 2'd2) ||
            (mode_q == MODE_THREE && cnt_q != 2'd0)) begin
          if (mode_q == MODE_THREE) begin
            if (cp == CpBullet) begin
              bnd.data[0] = ChDash;
              bnd.num     = 2'd1;
            end else if (!((cp >= CpSymLo && cp <= CpSymHi) ||
                           (cp >= CpVsLo && cp <= CpVsHi))) begin
              bnd.data = {b, fol_q, lead_q};
              bnd.num  = 2'd3;
            end
          end
          mode_d = MODE_NONE;
          cnt_d  = 2'd0;
        end else if (last) begin
          // truncated sequence: lead goes out plain
          bnd.data[0] = lead_q;
          if (keep_f) begin
            bnd.data[1] = fol_q;
            bnd.data[2] = b;
            bnd.num     = keep_b ? 2'd3 : 2'd2;
          end else begin
            bnd.data[1] = b;
            bnd.num     = keep_b ? 2'd2 : 2'd1;
          end
        end else begin
          if (cnt_q == 2'd0) fol_d = b;
          cnt_d = cnt_q + 2'd1;
        end
      end
      default: begin
        mode_d = MODE_NONE;
        if (is_markup(b)) begin
          bnd.num = 2'd0;
        end else if (last || b < Lead3Min) begin
          bnd.data[0] = b;
          bnd.num     = 2'd1;
        end else begin
          mode_d = (b >= Lead4Min) ? MODE_FOUR : MODE_THREE;
          lead_d = b;
          cnt_d  = 2'd0;
        end
      end
    endcase

    if (last) begin
      if (bnd.num == 2'd0) begin
        bnd.data    = '0;
        bnd.num     = 2'd1;
        bnd.present = 1'b0;
      end
      mode_d = MODE_NONE;
      lead_d = '0;
      fol_d  = '0;
      cnt_d  = 2'd0;
    end
  end

  assign wr_en_o  = accept && (bnd.num != 2'd0);
  assign bundle_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE;
      lead_q <= '0;
      fol_q  <= '0;
      cnt_q  <= 2'd0;
    end else if (accept) begin
      mode_q <= mode_d;
      lead_q <= lead_d;
      fol_q  <= fol_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- rtl/uts_queue.sv -----
// Bundle queue between the front and back stages.
module uts_queue import uts_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_en_i,
  input  bundle_t wr_data_i,
  input  logic    rd_en_i,
  output bundle_t rd_data_o,
  output logic    full_o,
  output logic    empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  bundle_t         mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_en_i && !full_o;
  assign do_rd   = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      if (do_rd) rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ----- rtl/uts_back.sv -----
// Back stage: hands out a bundle's results one beat at a time.
module uts_back import uts_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bundle_t   head_i,
  input  logic      q_empty_i,
  output logic      q_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_beat_t out_beat_o
);

  logic [1:0] idx_q;
  logic       final_beat;

  assign final_beat = (idx_q == head_i.num - 2'd1);
  assign empty_o    = q_empty_i;
  assign q_pop_o    = pop_i && !q_empty_i && final_beat;

  assign out_beat_o.out_byte     = head_i.data[idx_q];
  assign out_beat_o.byte_present = head_i.present;
  assign out_beat_o.end_mark     = head_i.last && final_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else if (pop_i && !q_empty_i) begin
      idx_q <= final_beat ? 2'd0 : idx_q + 2'd1;
    end
  end

endmodule

// ----- rtl/uts_checker.sv -----
// Port-level checker for the UTF-8 text sanitizer filter, with its bind.
`include "assert_macros.svh"

module uts_checker import uts_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_beat_t out_beat_o
);

  `ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> empty, "result shown during reset")
  `ASSERT_CLK(a_bare_end, (!empty && !out_beat_o.byte_present) |-> (out_beat_o.end_mark && out_beat_o.out_byte == 8'h00), "bare result without end mark or with data")
  `ASSERT_CLK(a_no_invent, $fell(empty) |-> $past(push && !full), "result appeared without an input beat")
  `ASSERT_CLK(a_hold, (!empty && !pop) |=> (!empty && $stable(out_beat_o)), "waiting result changed")

endmodule

bind utf8_text_sanitizer_filter uts_checker u_uts_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .out_beat_o (out_beat_o)
);

// ----- verif/utf8_text_sanitizer_filter_tb.sv -----
// Testbench for the UTF-8 text sanitizer filter: directed strings, then random text.
module utf8_text_sanitizer_filter_tb;
  import uts_pkg::*;

  // What the filter is waiting on after a lead byte.
  typedef enum logic [1:0] {
    HOLD_NONE  = 2'd0,
    HOLD_FOUR  = 2'd1,
    HOLD_THREE = 2'd2
  } hold_e;

  // Predicts the cleaned stream and checks each popped result against it.
  class sanitizer_scoreboard;
    out_beat_t   expected_q[$];
    logic [7:0]  step_bytes[$];
    int          err_count;
    hold_e       hold_mode;
    logic [7:0]  held_lead;
    logic [7:0]  held_fol[2];
    logic [1:0]  held_count;

    function new();
      err_count = 0;
      clear_hold();
    endfunction

    function void clear_hold();
      hold_mode   = HOLD_NONE;
      held_lead   = '0;
      held_fol[0] = '0;
      held_fol[1] = '0;
      held_count  = '0;
    endfunction

    function bit is_star_or_hash(logic [7:0] b);
      return (b == ChStar) || (b == ChHash);
    endfunction

    // A single beat never yields more than three bytes.
    function void put(logic [7:0] b);
      if (step_bytes.size() < 3) step_bytes.push_back(b);
    endfunction

    // Cut-off sequence: lead goes out plain, trailing markup is still dropped.
    function void emit_truncated(logic [7:0] cur);
      int cnt;
      cnt = (held_count > 2) ? 2 : held_count;
      put(held_lead);
      for (int k = 0; k < cnt; k++)
        if (!is_star_or_hash(held_fol[k])) put(held_fol[k]);
      if (!is_star_or_hash(cur)) put(cur);
    endfunction

    function void note_input(in_beat_t beat);
      logic [7:0]  b;
      logic        last;
      logic [15:0] cp;
      out_beat_t   r;
      b = beat.data_byte;
      last = beat.end_of_text;
      step_bytes.delete();
      case (hold_mode)
        HOLD_FOUR: begin
          if (held_count >= 2) begin
            clear_hold();
          end else if (last) begin
            emit_truncated(b);
          end else begin
            held_fol[held_count[0]] = b;
            held_count = held_count + 2'd1;
          end
        end
        HOLD_THREE: begin
          if (held_count >= 1) begin
            cp = {held_lead[3:0], held_fol[0][5:0], b[5:0]};
            if (cp == CpBullet) begin
              put(ChDash);
            end else if (!((cp >= CpSymLo && cp <= CpSymHi) ||
                           (cp >= CpVsLo && cp <= CpVsHi))) begin
              put(held_lead);
              put(held_fol[0]);
              put(b);
            end
            clear_hold();
          end else if (last) begin
            emit_truncated(b);
          end else begin
            held_fol[0] = b;
            held_count = 2'd1;
          end
        end
        default: begin
          hold_mode = HOLD_NONE;
          if (is_star_or_hash(b)) begin
            // dropped
          end else if (last) begin
            put(b);
          end else if (b >= Lead4Min) begin
            hold_mode  = HOLD_FOUR;
            held_lead  = b;
            held_count = '0;
          end else if (b >= Lead3Min) begin
            hold_mode  = HOLD_THREE;
            held_lead  = b;
            held_count = '0;
          end else begin
            put(b);
          end
        end
      endcase
      foreach (step_bytes[i]) begin
        r.out_byte     = step_bytes[i];
        r.byte_present = 1'b1;
        r.end_mark     = last && (i == step_bytes.size() - 1);
        expected_q.push_back(r);
      end
      if (last) begin
        if (step_bytes.size() == 0) begin
          r.out_byte     = '0;
          r.byte_present = 1'b0;
          r.end_mark     = 1'b1;
          expected_q.push_back(r);
        end
        clear_hold();
      end
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      err_count++;
    endtask

    task check_result(out_beat_t got);
      out_beat_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending: byte %02h present %0b end %0b",
                         got.out_byte, got.byte_present, got.end_mark));
      end else begin
        want = expected_q.pop_front();
        if (got.out_byte !== want.out_byte)
          report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
        if (got.byte_present !== want.byte_present)
          report($sformatf("byte_present %0b, want %0b",
                           got.byte_present, want.byte_present));
        if (got.end_mark !== want.end_mark)
          report($sformatf("end_mark %0b, want %0b", got.end_mark, want.end_mark));
      end
    endtask
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      push;
  logic      full;
  in_beat_t  in_beat_i;
  logic      empty;
  logic      pop = 1'b0;
  out_beat_t out_beat_o;

  sanitizer_scoreboard sb;

  // Text of the string being sent; the last byte carries end_of_text.
  logic [7:0]  text_q[$];
  int          beats_sent;
  int          burst_left;
  bit          steady;      // no gaps on the input side for this string
  logic [15:0] stall_pat = 16'h0001;
  int          pat_age = 0;

  utf8_text_sanitizer_filter uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_beat_i  (in_beat_i),
    .empty      (empty),
    .pop        (pop),
    .out_beat_o (out_beat_o)
  );

  always #6 clk_i = ~clk_i;

  // Receiver: pop follows a rotating 16-bit mask, reloaded when its age counter runs out.
  // Modes: always ready, sparse pops, or a plain random mask. Bit 0 is forced
  // so the sink never stalls forever.
  always @(posedge clk_i) begin
    if (pat_age == 0) begin
      case ($urandom_range(3))
        0:       stall_pat = 16'hFFFF;
        1:       stall_pat = 16'($urandom & $urandom);
        default: stall_pat = 16'($urandom);
      endcase
      stall_pat[0] = 1'b1;
      pat_age = 48;
    end
    pat_age--;
    pop <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[15:1]};
  end

  // Sample both handshakes with the values that held at the edge.
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) sb.note_input(in_beat_i);
    if (rst_ni && pop && !empty) sb.check_result(out_beat_o);
  end

  // Holds the beat until the filter takes it; returns on the accepting edge.
  task automatic send_beat(input logic [7:0] d, input logic l);
    push <= 1'b1;
    in_beat_i <= '{data_byte: d, end_of_text: l};
    do @(posedge clk_i); while (full);
    beats_sent++;
  endtask

  // Bursts of 1..12 beats; between bursts push is dropped for a gap unless steady.
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!steady) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) begin
      pace();
      send_beat(text_q[i], i == text_q.size() - 1);
    end
  endtask

  // Three-byte encoding of a code point.
  task automatic push_cp3(input logic [15:0] cp);
    text_q.push_back(Lead3Min | {4'h0, cp[15:12]});
    text_q.push_back(8'h80 | {2'b00, cp[11:6]});
    text_q.push_back(8'h80 | {2'b00, cp[5:0]});
  endtask

  // Random string: mostly well-formed text with the interesting code points
  // mixed in, plus noise bytes; about a quarter get cut short at the end so
  // that truncated leads show up.
  task automatic build_text();
    int ntok;
    int keep;
    text_q.delete();
    ntok = $urandom_range(1, 10);
    repeat (ntok) begin
      case ($urandom_range(11))
        0, 1, 2: text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        3:       text_q.push_back($urandom_range(1) ? ChStar : ChHash);
        4:       push_cp3(CpBullet);
        5:       push_cp3(16'($urandom_range(CpSymLo, CpSymHi)));
        6:       push_cp3(16'($urandom_range(CpVsLo, CpVsHi)));
        7: begin
          // three-byte lead with arbitrary followers
          text_q.push_back(Lead3Min | 8'($urandom_range(15)));
          text_q.push_back(8'($urandom_range(255)));
          text_q.push_back(8'($urandom_range(255)));
        end
        8: begin
          text_q.push_back(8'($urandom_range(Lead4Min, 8'hFF)));
          repeat (3) text_q.push_back(8'($urandom_range(255)));
        end
        9:       push_cp3(16'($urandom_range(16'hFFFF)));
        10:      text_q.push_back(8'($urandom_range(255)));
        default: text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
      endcase
    end
    if ($urandom_range(3) == 0 && text_q.size() > 1) begin
      keep = $urandom_range(1, text_q.size());
      while (text_q.size() > keep) void'(text_q.pop_back());
    end
  endtask

  initial begin
    sb = new();
    clk_i = 1'b0;
    rst_ni = 1'b0;
    push = 1'b0;
    in_beat_i = '0;
    beats_sent = 0;
    burst_left = 0;
    steady = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Plain bytes with markup dropped in between, last byte plain.
    text_q = '{8'h00, ChStar, ChHash, 8'h7F};
    send_text();
    // Bullet to dash, symbol block and variation selector vanish; the final
    // beat yields nothing so a bare end marker comes out.
    text_q = '{8'hE2, 8'h80, 8'hA2, 8'hE2, 8'h98, 8'h80, 8'hEF, 8'hB8, 8'h8F};
    send_text();
    // Ordinary three-byte char passes, four-byte char swallowed, a lead as
    // the last byte passes plain.
    text_q = '{8'hE4, 8'hB8, 8'hAD, 8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF};
    send_text();
    // Truncated three-byte lead; current byte is markup and dropped.
    text_q = '{8'hE2, ChStar};
    send_text();
    // Truncated four-byte lead with a held '#' that gets dropped on flush.
    text_q = '{8'hF5, ChHash, 8'h43};
    send_text();
    // String made only of markup.
    text_q = '{ChStar};
    send_text();

    while (beats_sent < 170) begin
      steady = ($urandom_range(4) == 0);
      build_text();
      send_text();
    end
    push <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    // Catch anything the filter emits beyond what was predicted.
    repeat (10) @(posedge clk_i);
    if (sb.err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/uts_pkg.sv
rtl/uts_front.sv
rtl/uts_queue.sv
rtl/uts_back.sv
rtl/utf8_text_sanitizer_filter.sv
rtl/uts_checker.sv
verif/utf8_text_sanitizer_filter_tb.sv
